### rtl/core/swtx_pkg.sv
// Shared types and constants for the stop-and-wait transmit coordinator.
package swtx_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned CMD_W    = 8;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned QLVL_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Default queue storage; one slot always stays empty.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Configuration register reset values.
  localparam logic [ADDR_W-1:0] PARTNER_ADDRESS_RST   = 8'd7;
  localparam logic [CNT_W-1:0]  TIMEOUT_TICKS_RST     = 16'd50;
  localparam logic [CMD_W-1:0]  HEARTBEAT_COMMAND_RST = 8'd0;
  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST       = 8'd0;

  // Value carried by a heartbeat packet.
  localparam logic [VAL_W-1:0] HEARTBEAT_VAL = 16'h0000;

  // Request codes of an input item.
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_RECV = 2'd1,
    REQ_TICK = 2'd2,
    REQ_POLL = 2'd3
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTNER_ADDRESS   = 2'd0,
    CFG_TIMEOUT_TICKS     = 2'd1,
    CFG_HEARTBEAT_COMMAND = 2'd2,
    CFG_OWN_ADDRESS       = 2'd3
  } cfg_idx_t;

  // Input item.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [CMD_W-1:0]  cmd_in;
    logic [VAL_W-1:0]  val_in;
    logic [ADDR_W-1:0] addr_in;
    logic              tx_idle;
    logic              rx_busy;
  } swtx_in_t;

  // Result item.
  typedef struct packed {
    logic              send_valid;
    logic [CMD_W-1:0]  send_cmd;
    logic [VAL_W-1:0]  send_val;
    logic [ADDR_W-1:0] send_addr;
    logic              heartbeat;
    logic              push_accepted;
    logic [QLVL_W-1:0] queue_level;
  } swtx_out_t;

  // One queued command.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  val;
    logic [ADDR_W-1:0] addr;
  } swtx_entry_t;

endpackage

### rtl/core/stop_and_wait_tx_coordinator_core.sv
// Top level of the stop-and-wait transmit coordinator with its command queue.
// The input item and the result item are each registered.
// Throughput: one item per cycle when not stalled; the queue head is prefetched
// into a register so the queue memory read never sits in the update path.
// Reset (rst_n low, synchronous): pointers, turn flag, idle counter and config
// return to defaults; the queue memory is not cleared.
module stop_and_wait_tx_coordinator_core #(
  parameter int unsigned QUEUE_DEPTH = swtx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  swtx_pkg::swtx_in_t                in_data,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output swtx_pkg::swtx_out_t               out_data,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [swtx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swtx_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LEV_W = PTR_W + 1;
  localparam int unsigned OUT_LEV_W = swtx_pkg::QLVL_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LEV_W-1:0] LEV_DEPTH = LEV_W'(QUEUE_DEPTH);

  // Configuration registers
  logic [swtx_pkg::ADDR_W-1:0] partner_address_r;
  logic [swtx_pkg::CNT_W-1:0]  timeout_ticks_r;
  logic [swtx_pkg::CMD_W-1:0]  heartbeat_command_r;
  logic [swtx_pkg::ADDR_W-1:0] own_address_r;

  // Pipeline registers
  logic                 in_v_r, in_v_nxt;
  swtx_pkg::swtx_in_t   in_r;
  logic                 out_v_r, out_v_nxt;
  swtx_pkg::swtx_out_t  out_r;

  // Coordinator state
  logic [PTR_W-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic                         turn_r, turn_nxt;
  logic [swtx_pkg::CNT_W-1:0]   idle_r, idle_nxt;

  // Queue memory and prefetched head entry
  swtx_pkg::swtx_entry_t        mem [QUEUE_DEPTH];
  swtx_pkg::swtx_entry_t        head_r;
  swtx_pkg::swtx_entry_t        wr_entry;
  logic                         wr_en;

  // Handshake and update logic signals
  logic                 out_free;
  logic                 fire;
  logic                 in_accept;
  logic [PTR_W-1:0]     wr_ptr_inc, rd_ptr_inc;
  logic                 q_empty;
  logic                 timeout_hit;
  logic                 turn_eff;
  logic                 send;
  logic [LEV_W-1:0]     level_diff;
  logic [LEV_W-1:0]     level;
  swtx_pkg::swtx_out_t  res;

  // Flow control: the result register frees up when it is empty or taken.
  assign out_free  = !out_v_r || !out_stall;
  assign fire      = in_v_r && out_free;
  assign in_stall  = in_v_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign in_v_nxt  = in_accept ? 1'b1 : (fire ? 1'b0 : in_v_r);
  assign out_v_nxt = fire ? 1'b1 : (out_stall ? out_v_r : 1'b0);

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Ring pointer increments with wrap at the queue depth.
  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign q_empty    = (wr_ptr_r == rd_ptr_r);

  assign timeout_hit = (idle_r >= timeout_ticks_r);
  assign turn_eff    = turn_r || timeout_hit;
  assign send        = turn_eff && in_r.tx_idle && !in_r.rx_busy;

  assign wr_entry = '{cmd: in_r.cmd_in, val: in_r.val_in, addr: in_r.addr_in};

  // Single-pass item update: next state and the result item.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    turn_nxt   = turn_r;
    idle_nxt   = idle_r;
    wr_en      = 1'b0;
    res        = '0;
    if (fire) begin
      case (in_r.req_type)
        swtx_pkg::REQ_PUSH: begin
          if (wr_ptr_inc != rd_ptr_r) begin
            wr_en             = 1'b1;
            wr_ptr_nxt        = wr_ptr_inc;
            res.push_accepted = 1'b1;
          end
        end
        swtx_pkg::REQ_RECV: begin
          if (in_r.addr_in == partner_address_r) begin
            turn_nxt = 1'b1;
            idle_nxt = '0;
          end
        end
        swtx_pkg::REQ_TICK: begin
          if (idle_r != '1) begin
            idle_nxt = idle_r + 1'b1;
          end
        end
        swtx_pkg::REQ_POLL: begin
          if (timeout_hit) begin
            turn_nxt = 1'b1;
            idle_nxt = '0;
          end
          if (send) begin
            res.send_valid = 1'b1;
            turn_nxt       = 1'b0;
            if (!q_empty) begin
              res.send_cmd  = head_r.cmd;
              res.send_val  = head_r.val;
              res.send_addr = head_r.addr;
              rd_ptr_nxt    = rd_ptr_inc;
            end else begin
              res.send_cmd  = heartbeat_command_r;
              res.send_val  = swtx_pkg::HEARTBEAT_VAL;
              res.send_addr = own_address_r;
              res.heartbeat = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // Queue fill level after the update, modulo the depth.
    level_diff = {1'b0, wr_ptr_nxt} - {1'b0, rd_ptr_nxt};
    if (wr_ptr_nxt < rd_ptr_nxt) begin
      level = level_diff + LEV_DEPTH;
    end else begin
      level = level_diff;
    end
    res.queue_level = OUT_LEV_W'(level);
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r              <= 1'b0;
      out_v_r             <= 1'b0;
      wr_ptr_r            <= '0;
      rd_ptr_r            <= '0;
      turn_r              <= 1'b0;
      idle_r              <= '0;
      partner_address_r   <= swtx_pkg::PARTNER_ADDRESS_RST;
      timeout_ticks_r     <= swtx_pkg::TIMEOUT_TICKS_RST;
      heartbeat_command_r <= swtx_pkg::HEARTBEAT_COMMAND_RST;
      own_address_r       <= swtx_pkg::OWN_ADDRESS_RST;
    end else begin
      in_v_r   <= in_v_nxt;
      out_v_r  <= out_v_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      turn_r   <= turn_nxt;
      idle_r   <= idle_nxt;
      if (cfg_we) begin
        case (cfg_index)
          swtx_pkg::CFG_PARTNER_ADDRESS:
            partner_address_r <= cfg_wdata[swtx_pkg::ADDR_W-1:0];
          swtx_pkg::CFG_TIMEOUT_TICKS:
            timeout_ticks_r <= cfg_wdata[swtx_pkg::CNT_W-1:0];
          swtx_pkg::CFG_HEARTBEAT_COMMAND:
            heartbeat_command_r <= cfg_wdata[swtx_pkg::CMD_W-1:0];
          swtx_pkg::CFG_OWN_ADDRESS:
            own_address_r <= cfg_wdata[swtx_pkg::ADDR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: input item and result item.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  // Queue memory: write at the write pointer, prefetch the next head entry.
  // A push into an empty queue lands on the head slot and is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_entry;
    end
    if (wr_en && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wr_entry;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

### rtl/core/swtx_chk.sv
// Port-level assertion checker for the transmit coordinator, with its bind.
module swtx_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input swtx_pkg::swtx_out_t    out_data
);

  // A stalled result item holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only comes from a stalled pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A heartbeat is a sent packet with a zero value.
  a_heartbeat_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.heartbeat |->
      out_data.send_valid && (out_data.send_val == swtx_pkg::HEARTBEAT_VAL))
    else $error("malformed heartbeat item");

  // An item never both sends a packet and stores a push.
  a_send_xor_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.send_valid |-> !out_data.push_accepted)
    else $error("send and push in one result item");

endmodule

bind stop_and_wait_tx_coordinator_core swtx_chk u_swtx_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/tb.sv
// Self-checking testbench for the stop-and-wait transmit coordinator core.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH     = swtx_pkg::QUEUE_DEPTH_DEF;
  localparam int HOLD_LEN   = 60;
  localparam int DOG_LIMIT  = 2000;
  localparam int PRINT_MAX  = 40;
  localparam int IN_W       = $bits(swtx_pkg::swtx_in_t);

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  swtx_pkg::swtx_in_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  swtx_pkg::swtx_out_t           out_data;
  logic                          cfg_we;
  logic [swtx_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swtx_pkg::CFG_DATA_W-1:0] cfg_wdata;

  stop_and_wait_tx_coordinator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Coordinator state as the testbench sees it.
  swtx_pkg::swtx_entry_t       cmd_ring [QDEPTH];
  int                          ring_wr;
  int                          ring_rd;
  bit                          turn_held;
  logic [swtx_pkg::CNT_W-1:0]  idle_ticks;
  logic [swtx_pkg::ADDR_W-1:0] partner_addr;
  logic [swtx_pkg::CNT_W-1:0]  timeout_lim;
  logic [swtx_pkg::CMD_W-1:0]  hb_cmd;
  logic [swtx_pkg::ADDR_W-1:0] own_addr;

  // Results still owed by the block, oldest first.
  swtx_pkg::swtx_out_t pending_results [$];

  // Directed stimulus table.
  typedef struct {
    swtx_pkg::swtx_in_t  item;
    bit                  typed;
    swtx_pkg::swtx_out_t want;
  } dir_row_t;
  dir_row_t dir_rows [$];

  int  mismatches;
  int  items_done;
  int  results_done;
  int  packets_sent;
  int  heartbeats_sent;
  int  pushes_dropped;
  int  quiet_cycles;
  bit  calm;
  bit  hold_req;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int ring_next(int p);
    return (p + 1 >= QDEPTH) ? 0 : p + 1;
  endfunction

  // Advance the coordinator state by one item and return the result it causes.
  function automatic swtx_pkg::swtx_out_t predict_step(swtx_pkg::swtx_in_t it);
    swtx_pkg::swtx_out_t res;
    int                  nx;
    res = '0;
    case (swtx_pkg::req_type_t'(it.req_type))
      swtx_pkg::REQ_PUSH: begin
        nx = ring_next(ring_wr);
        if (nx != ring_rd) begin
          cmd_ring[ring_wr] = '{cmd: it.cmd_in, val: it.val_in, addr: it.addr_in};
          ring_wr = nx;
          res.push_accepted = 1'b1;
        end
      end
      swtx_pkg::REQ_RECV: begin
        if (it.addr_in == partner_addr) begin
          turn_held  = 1'b1;
          idle_ticks = '0;
        end
      end
      swtx_pkg::REQ_TICK: begin
        if (idle_ticks != '1) idle_ticks = idle_ticks + 1'b1;
      end
      default: begin
        // A poll past the timeout takes the turn even if nothing goes out.
        if (idle_ticks >= timeout_lim) begin
          turn_held  = 1'b1;
          idle_ticks = '0;
        end
        if (turn_held && it.tx_idle && !it.rx_busy) begin
          res.send_valid = 1'b1;
          if (ring_wr != ring_rd) begin
            res.send_cmd  = cmd_ring[ring_rd].cmd;
            res.send_val  = cmd_ring[ring_rd].val;
            res.send_addr = cmd_ring[ring_rd].addr;
            ring_rd = ring_next(ring_rd);
          end else begin
            res.send_cmd  = hb_cmd;
            res.send_val  = swtx_pkg::HEARTBEAT_VAL;
            res.send_addr = own_addr;
            res.heartbeat = 1'b1;
          end
          turn_held = 1'b0;
        end
      end
    endcase
    res.queue_level = swtx_pkg::QLVL_W'((ring_wr + QDEPTH - ring_rd) % QDEPTH);
    return res;
  endfunction

  function automatic swtx_pkg::swtx_in_t mk_item(swtx_pkg::req_type_t kind, logic [7:0] cmd,
                                                 logic [15:0] val, logic [7:0] addr,
                                                 bit txi, bit rxb);
    swtx_pkg::swtx_in_t it;
    it.req_type = kind;
    it.cmd_in   = cmd;
    it.val_in   = val;
    it.addr_in  = addr;
    it.tx_idle  = txi;
    it.rx_busy  = rxb;
    return it;
  endfunction

  function automatic swtx_pkg::swtx_out_t mk_result(bit sv, logic [7:0] cmd, logic [15:0] val,
                                                    logic [7:0] addr, bit hb, bit acc,
                                                    logic [3:0] lvl);
    swtx_pkg::swtx_out_t res;
    res.send_valid    = sv;
    res.send_cmd      = cmd;
    res.send_val      = val;
    res.send_addr     = addr;
    res.heartbeat     = hb;
    res.push_accepted = acc;
    res.queue_level   = lvl;
    return res;
  endfunction

  // Random item, biased toward traffic that moves the queue and the turn.
  function automatic swtx_pkg::swtx_in_t gen_item();
    swtx_pkg::swtx_in_t it;
    int                 pick;
    it   = swtx_pkg::swtx_in_t'(IN_W'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      // Fully random noise item.
    end else if (pick < 40) begin
      it.req_type = swtx_pkg::REQ_PUSH;
    end else if (pick < 55) begin
      it.req_type = swtx_pkg::REQ_RECV;
      if ($urandom_range(0, 9) < 7) it.addr_in = partner_addr;
    end else if (pick < 78) begin
      it.req_type = swtx_pkg::REQ_TICK;
    end else begin
      it.req_type = swtx_pkg::REQ_POLL;
      if ($urandom_range(0, 3) != 0) begin
        it.tx_idle = 1'b1;
        it.rx_busy = 1'b0;
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("tb: mismatch in %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
  endtask

  task automatic add_row(swtx_pkg::swtx_in_t it, bit typed, swtx_pkg::swtx_out_t want);
    dir_rows.push_back('{item: it, typed: typed, want: want});
  endtask

  // Offer one item, hold it until accepted, then log what it should produce.
  task automatic offer_item(swtx_pkg::swtx_in_t it, bit typed, swtx_pkg::swtx_out_t want);
    swtx_pkg::swtx_out_t guess;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    guess = predict_step(it);
    pending_results.push_back(typed ? want : guess);
    items_done++;
    if (guess.send_valid) packets_sent++;
    if (guess.heartbeat) heartbeats_sent++;
    if (it.req_type == swtx_pkg::REQ_PUSH && !guess.push_accepted) pushes_dropped++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every owed result has come out.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(swtx_pkg::cfg_idx_t idx, logic [swtx_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      swtx_pkg::CFG_PARTNER_ADDRESS:   partner_addr = data[swtx_pkg::ADDR_W-1:0];
      swtx_pkg::CFG_TIMEOUT_TICKS:     timeout_lim  = data[swtx_pkg::CNT_W-1:0];
      swtx_pkg::CFG_HEARTBEAT_COMMAND: hb_cmd       = data[swtx_pkg::CMD_W-1:0];
      swtx_pkg::CFG_OWN_ADDRESS:       own_addr     = data[swtx_pkg::ADDR_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Write all four registers; the 8-bit ones get junk in the upper byte.
  task automatic set_regs(logic [7:0] partner, logic [15:0] tmo, logic [7:0] hb,
                          logic [7:0] own);
    write_reg(swtx_pkg::CFG_PARTNER_ADDRESS, {8'($urandom), partner});
    write_reg(swtx_pkg::CFG_TIMEOUT_TICKS, tmo);
    write_reg(swtx_pkg::CFG_HEARTBEAT_COMMAND, {8'($urandom), hb});
    write_reg(swtx_pkg::CFG_OWN_ADDRESS, {8'($urandom), own});
  endtask

  task automatic run_random(int count, bit hold_first, bit pause_mid);
    if (hold_first) hold_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      offer_item(gen_item(), 1'b0, '0);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    swtx_pkg::swtx_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_done++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_data.queue_level), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.send_valid != want.send_valid)
            report_mismatch("send_valid", 32'(out_data.send_valid), 32'(want.send_valid));
          if (out_data.send_cmd != want.send_cmd)
            report_mismatch("send_cmd", 32'(out_data.send_cmd), 32'(want.send_cmd));
          if (out_data.send_val != want.send_val)
            report_mismatch("send_val", 32'(out_data.send_val), 32'(want.send_val));
          if (out_data.send_addr != want.send_addr)
            report_mismatch("send_addr", 32'(out_data.send_addr), 32'(want.send_addr));
          if (out_data.heartbeat != want.heartbeat)
            report_mismatch("heartbeat", 32'(out_data.heartbeat), 32'(want.heartbeat));
          if (out_data.push_accepted != want.push_accepted)
            report_mismatch("push_accepted", 32'(out_data.push_accepted),
                            32'(want.push_accepted));
          if (out_data.queue_level != want.queue_level)
            report_mismatch("queue_level", 32'(out_data.queue_level), 32'(want.queue_level));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= DOG_LIMIT) begin
        $display("tb: watchdog expired after %0d cycles without a handshake", quiet_cycles);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    mismatches = 0;
    items_done = 0;
    results_done = 0;
    packets_sent = 0;
    heartbeats_sent = 0;
    pushes_dropped = 0;
    quiet_cycles = 0;
    ring_wr      = 0;
    ring_rd      = 0;
    turn_held    = 1'b0;
    idle_ticks   = '0;
    partner_addr = swtx_pkg::PARTNER_ADDRESS_RST;
    timeout_lim  = swtx_pkg::TIMEOUT_TICKS_RST;
    hb_cmd       = swtx_pkg::HEARTBEAT_COMMAND_RST;
    own_addr     = swtx_pkg::OWN_ADDRESS_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows under the reset register values.
    add_row(mk_item(swtx_pkg::REQ_POLL, 8'h12, 16'h3456, 8'h78, 1, 0), 1,
            mk_result(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(swtx_pkg::REQ_RECV, 8'hff, 16'hffff, 8'h06, 1, 1), 1,
            mk_result(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(swtx_pkg::REQ_RECV, 8'h00, 16'h0000, 8'h07, 0, 0), 1,
            mk_result(0, 0, 0, 0, 0, 0, 0));
    // Turn held but transmitter busy, then receiver busy: nothing goes out.
    add_row(mk_item(swtx_pkg::REQ_POLL, 8'hff, 16'hffff, 8'hff, 0, 0), 1,
            mk_result(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(swtx_pkg::REQ_POLL, 8'h00, 16'h0000, 8'h00, 1, 1), 1,
            mk_result(0, 0, 0, 0, 0, 0, 0));
    // Empty queue: the poll sends a heartbeat.
    add_row(mk_item(swtx_pkg::REQ_POLL, 8'h5a, 16'ha5a5, 8'h3c, 1, 0), 1,
            mk_result(1, 0, 0, 0, 1, 0, 0));
    add_row(mk_item(swtx_pkg::REQ_PUSH, 8'hff, 16'hffff, 8'hff, 0, 0), 1,
            mk_result(0, 0, 0, 0, 0, 1, 1));
    add_row(mk_item(swtx_pkg::REQ_PUSH, 8'h00, 16'h0000, 8'h00, 1, 1), 1,
            mk_result(0, 0, 0, 0, 0, 1, 2));
    add_row(mk_item(swtx_pkg::REQ_PUSH, 8'ha5, 16'h5a5a, 8'h3c, 1, 1), 0, '0);
    for (int i = 0; i < QDEPTH - 4; i++)
      add_row(mk_item(swtx_pkg::REQ_PUSH, 8'($urandom), 16'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom)), 0, '0);
    // Full queue: this push is dropped.
    add_row(mk_item(swtx_pkg::REQ_PUSH, 8'h11, 16'h2222, 8'h33, 1, 0), 1,
            mk_result(0, 0, 0, 0, 0, 0, 15));
    add_row(mk_item(swtx_pkg::REQ_TICK, 8'hff, 16'hffff, 8'h07, 1, 0), 0, '0);
    add_row(mk_item(swtx_pkg::REQ_RECV, 8'h99, 16'h8888, 8'h07, 0, 1), 1,
            mk_result(0, 0, 0, 0, 0, 0, 15));
    add_row(mk_item(swtx_pkg::REQ_POLL, 8'h00, 16'h0000, 8'h00, 1, 0),
            1, mk_result(1, 8'hff, 16'hffff, 8'hff, 0, 0, 14));
    foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Reset register values, with one long receiver hold-off to back up the block.
    drain();
    run_random(120, 1'b1, 1'b0);

    // Timeout of one tick, partner address zero, all-ones heartbeat fields.
    drain();
    set_regs(8'h00, 16'd1, 8'hff, 8'hff);
    run_random(130, 1'b0, 1'b1);

    // Timeout zero: every poll takes the turn.
    drain();
    set_regs(8'hff, 16'd0, 8'h5a, 8'h81);
    run_random(130, 1'b0, 1'b0);

    // Largest timeout: only frames from the partner hand over the turn.
    drain();
    set_regs(8'($urandom), 16'hffff, 8'($urandom), 8'($urandom));
    run_random(100, 1'b0, 1'b0);

    // Random registers, small timeout, no idling on either side.
    drain();
    set_regs(8'($urandom), 16'($urandom_range(1, 40)), 8'($urandom), 8'($urandom));
    calm = 1'b1;
    run_random(150, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("tb: %0d items in, %0d results checked, %0d mismatches", items_done,
             results_done, mismatches);
    $display("tb: %0d packets sent (%0d heartbeats), %0d pushes dropped on a full queue",
             packets_sent, heartbeats_sent, pushes_dropped);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/swtx_pkg.sv
rtl/core/stop_and_wait_tx_coordinator_core.sv
rtl/core/swtx_chk.sv
sim/tb.sv
